// ===== hw/rtl/sdlc_pkg.sv =====
// Shared types and constants for the spatial duty LED chase block.
// No dependencies; imported by sdlc_ctrl, sdlc_dp and the core top level.
`timescale 1ns / 1ps

package sdlc_pkg;

	localparam int MAX_LEDS = 64;
	localparam int IDX_W    = $clog2(MAX_LEDS);
	localparam int LEN_W    = IDX_W + 1;

	// Register indexes (byte address = 4 * index).
	localparam logic [2:0] REG_COLOR_VALID = 3'd0;
	localparam logic [2:0] REG_COLOR_RED   = 3'd1;
	localparam logic [2:0] REG_COLOR_GREEN = 3'd2;
	localparam logic [2:0] REG_COLOR_BLUE  = 3'd3;
	localparam logic [2:0] REG_COLOR_WHITE = 3'd4;
	localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;
	localparam logic [2:0] REG_SPEED       = 3'd6;
	localparam logic [2:0] REG_STRIP_LEN   = 3'd7;

	localparam logic [6:0] PCT_FULL = 7'd100;

	// Chase interval: MAX - (MAX - MIN) * speed / 100, exact per percent step.
	localparam int INTERVAL_MAX_US  = 200000;
	localparam int INTERVAL_MIN_US  = 10000;
	localparam int INTERVAL_STEP_US = (INTERVAL_MAX_US - INTERVAL_MIN_US) / 100;
	localparam int INTERVAL_W       = 18;

	// x / 100 == (x * 1311) >> 17 for every x = length * pct with
	// length <= 64 and pct <= 99.
	localparam int           DIV100_SHIFT = 17;
	localparam logic [10:0]  DIV100_MUL   = 11'd1311;

	typedef struct packed {
		logic       color_valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
		logic [6:0] brightness;
		logic [6:0] speed;
		logic [6:0] strip_length;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic fill_start;
		logic mod_step;
		logic adv_start;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic fill;
		logic mod_done;
		logic out_free;
		logic last_pix;
	} sts_t;

endpackage

// ===== hw/rtl/sdlc_ctrl.sv =====
// Sequencer for one frame tick: setup, offset reduction, advance, pixel emit.
// Depends on sdlc_pkg.
`timescale 1ns / 1ps

module sdlc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  sdlc_pkg::sts_t sts,
	output sdlc_pkg::cmd_t cmd
);
	import sdlc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CLASS,
		ST_MOD,
		ST_ADV,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_CALC;
				end
				ST_CALC: state_q <= ST_CLASS;
				ST_CLASS: begin
					if (sts.skip) state_q <= ST_IDLE;
					else if (sts.fill) state_q <= ST_EMIT;
					else state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (sts.mod_done) state_q <= ST_ADV;
				end
				ST_ADV: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (sts.out_free && sts.last_pix) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && s_tvalid;
		cmd.calc       = (state_q == ST_CALC);
		cmd.fill_start = (state_q == ST_CLASS) && !sts.skip && sts.fill;
		cmd.mod_step   = (state_q == ST_MOD) && !sts.mod_done;
		cmd.adv_start  = (state_q == ST_ADV);
		cmd.emit_step  = (state_q == ST_EMIT) && sts.out_free;
	end

	property p_emit_only_from_setup;
		@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> ($past(state_q) == ST_ADV || $past(state_q) == ST_CLASS);
	endproperty
	a_emit_only_from_setup: assert property (p_emit_only_from_setup)
		else $error("emit entered without setup");

	property p_one_cmd;
		@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd);
	endproperty
	a_one_cmd: assert property (p_one_cmd) else $error("more than one command active");

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_tready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy)
		else $error("tick accepted while busy");

endmodule

// ===== hw/rtl/sdlc_dp.sv =====
// Datapath: tick setup arithmetic, chase state, Bresenham spacing and the
// output register. Depends on sdlc_pkg; driven by sdlc_ctrl.
`timescale 1ns / 1ps

module sdlc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdlc_pkg::cfg_t       cfg,
	input  sdlc_pkg::cmd_t       cmd,
	output sdlc_pkg::sts_t       sts,
	input  logic [63:0]          now_us,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [sdlc_pkg::IDX_W-1:0] pixel_index,
	output logic [7:0]           pixel_red,
	output logic [7:0]           pixel_green,
	output logic [7:0]           pixel_blue,
	output logic [7:0]           pixel_white,
	output logic                 last_pixel
);
	import sdlc_pkg::*;

	// control state
	logic [IDX_W-1:0] chase_q;
	logic [63:0]      last_adv_q;
	logic             advanced_q;
	logic             out_valid_q;

	// per-tick payload
	logic [63:0]           now_q;
	logic [63:0]           diff_q;
	logic [LEN_W-1:0]      total_q;
	logic [12:0]           prod_q;
	logic [LEN_W-1:0]      on_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [IDX_W-1:0]      off_q;
	logic [IDX_W-1:0]      pos_q;
	logic [LEN_W-1:0]      acc_q;
	logic [LEN_W-1:0]      cnt_q;
	logic                  fill_q;
	logic                  fill_lit_q;

	logic [LEN_W-1:0]  total_d;
	logic [23:0]       div_prod;
	logic [LEN_W:0]    sum;
	logic              lit;
	logic              go;
	logic              far;
	logic [LEN_W-1:0]  off_inc;
	logic [IDX_W-1:0]  new_off;
	logic [LEN_W-1:0]  pos_inc;
	logic              fill_dark;
	logic              fill_full;

	assign total_d = (cfg.strip_length > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : cfg.strip_length;
	assign div_prod = {11'd0, prod_q} * {13'd0, DIV100_MUL};

	// Spaced-case chase decision.
	assign far = (diff_q[63:INTERVAL_W] != '0) || (diff_q[INTERVAL_W-1:0] >= interval_q);
	assign go  = (cfg.speed != '0) && ((cfg.speed >= PCT_FULL) || !advanced_q || far);

	assign off_inc = {1'b0, off_q} + LEN_W'(1);
	assign new_off = (off_inc == total_q) ? '0 : off_inc[IDX_W-1:0];

	assign fill_dark = (cfg.brightness == '0);
	assign fill_full = (cfg.brightness >= PCT_FULL);

	assign sum     = {1'b0, acc_q} + {1'b0, on_q};
	assign lit     = fill_q ? fill_lit_q : (sum >= {1'b0, total_q});
	assign pos_inc = {1'b0, pos_q} + LEN_W'(1);

	assign sts.skip     = !cfg.color_valid || (total_q == '0);
	assign sts.fill     = fill_dark || fill_full || (on_q == '0) || (on_q >= total_q);
	assign sts.mod_done = ({1'b0, off_q} < total_q);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last_pix = ((cnt_q + LEN_W'(1)) == total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chase_q     <= '0;
			last_adv_q  <= '0;
			advanced_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.adv_start && go) begin
				chase_q    <= new_off;
				last_adv_q <= now_q;
				advanced_q <= 1'b1;
			end
			if (cmd.emit_step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q   <= now_us;
			diff_q  <= now_us - last_adv_q;
			total_q <= total_d;
			prod_q  <= 13'(total_d) * 13'(cfg.brightness);
		end
		if (cmd.calc) begin
			on_q       <= div_prod[DIV100_SHIFT +: LEN_W];
			interval_q <= INTERVAL_W'(INTERVAL_MAX_US) -
				INTERVAL_W'(cfg.speed * INTERVAL_W'(INTERVAL_STEP_US));
			off_q      <= chase_q;
		end
		if (cmd.fill_start) begin
			fill_q     <= 1'b1;
			fill_lit_q <= !fill_dark && (fill_full || (on_q != '0));
			pos_q      <= '0;
			cnt_q      <= '0;
			acc_q      <= '0;
		end
		if (cmd.mod_step) begin
			off_q <= off_q - total_q[IDX_W-1:0];
		end
		if (cmd.adv_start) begin
			fill_q <= 1'b0;
			pos_q  <= go ? new_off : off_q;
			cnt_q  <= '0;
			acc_q  <= '0;
		end
		if (cmd.emit_step) begin
			pixel_index <= pos_q;
			pixel_red   <= lit ? cfg.red   : 8'd0;
			pixel_green <= lit ? cfg.green : 8'd0;
			pixel_blue  <= lit ? cfg.blue  : 8'd0;
			pixel_white <= lit ? cfg.white : 8'd0;
			last_pixel  <= sts.last_pix;
			acc_q       <= (!fill_q && lit) ? LEN_W'(sum - {1'b0, total_q}) : sum[LEN_W-1:0];
			pos_q       <= (pos_inc == total_q) ? '0 : pos_inc[IDX_W-1:0];
			cnt_q       <= cnt_q + LEN_W'(1);
		end
	end

	assign out_valid = out_valid_q;

	property p_pos_in_range;
		@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> ({1'b0, pos_q} < total_q);
	endproperty
	a_pos_in_range: assert property (p_pos_in_range) else $error("pixel index past strip");

	property p_acc_in_range;
		@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step && !fill_q) |-> (acc_q < total_q);
	endproperty
	a_acc_in_range: assert property (p_acc_in_range) else $error("spacing accumulator overflow");

	property p_count_done;
		@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step && sts.last_pix) |=> (cnt_q == total_q);
	endproperty
	a_count_done: assert property (p_count_done) else $error("pixel count mismatch");

endmodule

// ===== hw/rtl/spatial_duty_led_chase_core.sv =====
// A tick is taken in IDLE; the first pixel transfer is offered after CALC and
// CLASS for a full/dark fill, and after CALC, CLASS, MOD and ADV in the
// spaced case, where MOD makes r (0..31) subtractions reducing a stale
// chase offset mod length.
// Throughput: one pixel per cycle while the sink is ready; no new tick is
// taken until its last pixel is emitted; a tick that draws nothing ends in CLASS.
// Reset (arst_n low): config to defaults, chase offset and timer to zero.
`timescale 1ns / 1ps

module spatial_duty_led_chase_core (
	input  logic        clk,
	input  logic        arst_n,
	// input tick stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] now_us
	// pixel write stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [5:0] pixel_index, [13:6] pixel_red,
	                               // [21:14] pixel_green, [29:22] pixel_blue,
	                               // [37:30] pixel_white, [39:38] zero
	output logic        m_tlast,   // last_pixel
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sdlc_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	logic             reg_wr;
	logic [2:0]       reg_idx;
	logic [IDX_W-1:0] pixel_index;
	logic [7:0]       pixel_red;
	logic [7:0]       pixel_green;
	logic [7:0]       pixel_blue;
	logic [7:0]       pixel_white;

	// ------------------------------------------------------------------
	// Register file. Zero wait states; writes land in the access phase.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_valid  <= 1'b0;
			cfg_q.red          <= '0;
			cfg_q.green        <= '0;
			cfg_q.blue         <= '0;
			cfg_q.white        <= '0;
			cfg_q.brightness   <= PCT_FULL;
			cfg_q.speed        <= '0;
			cfg_q.strip_length <= 7'(MAX_LEDS);
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_COLOR_VALID: cfg_q.color_valid  <= pwdata[0];
				REG_COLOR_RED:   cfg_q.red          <= pwdata[7:0];
				REG_COLOR_GREEN: cfg_q.green        <= pwdata[7:0];
				REG_COLOR_BLUE:  cfg_q.blue         <= pwdata[7:0];
				REG_COLOR_WHITE: cfg_q.white        <= pwdata[7:0];
				REG_BRIGHTNESS:  cfg_q.brightness   <= pwdata[6:0];
				REG_SPEED:       cfg_q.speed        <= pwdata[6:0];
				REG_STRIP_LEN:   cfg_q.strip_length <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COLOR_VALID: prdata = {31'd0, cfg_q.color_valid};
			REG_COLOR_RED:   prdata = {24'd0, cfg_q.red};
			REG_COLOR_GREEN: prdata = {24'd0, cfg_q.green};
			REG_COLOR_BLUE:  prdata = {24'd0, cfg_q.blue};
			REG_COLOR_WHITE: prdata = {24'd0, cfg_q.white};
			REG_BRIGHTNESS:  prdata = {25'd0, cfg_q.brightness};
			REG_SPEED:       prdata = {25'd0, cfg_q.speed};
			REG_STRIP_LEN:   prdata = {25'd0, cfg_q.strip_length};
			default:         prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Controller: walks setup, offset reduction, advance, then one pixel
	// transfer per free output slot; a fill skips reduction and advance.
	// ------------------------------------------------------------------
	sdlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ------------------------------------------------------------------
	// Datapath: on-count via reciprocal multiply, chase timer compare,
	// Bresenham accumulator and the output register stage.
	// ------------------------------------------------------------------
	sdlc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.now_us      (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pixel_index (pixel_index),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.pixel_white (pixel_white),
		.last_pixel  (m_tlast)
	);

	assign m_tdata = {2'b00, pixel_white, pixel_blue, pixel_green, pixel_red, pixel_index};

endmodule
